### rtl/btds_pkg.sv
// ----------------------------------------------------------------------------
// btds_pkg: shared types and constants for the byte translate/delete/squeeze
// filter. Holds the table entry layout, the item view seen by the filter
// stage and the configuration register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package btds_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgFoldEnable = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFoldChar   = 1'b1;
  localparam int unsigned CfgDataW = 8;

  // Item kinds carried in the action field
  localparam logic ActData       = 1'b0;
  localparam logic ActTableWrite = 1'b1;

  // One table entry: squeeze mark, delete mark and translation target
  typedef struct packed {
    logic       squeeze;
    logic       del;
    logic [7:0] target;
  } entry_t;

  // The parts of an input item the filter stage needs after the lookup
  typedef struct packed {
    logic       action;
    logic       new_stream;
    logic [7:0] byte_value;
  } item_t;

endpackage

`default_nettype wire

### rtl/byte_translate_delete_squeeze.sv
// ----------------------------------------------------------------------------
// byte_translate_delete_squeeze: tr-style byte stream filter
// Translates, deletes or squeezes each data byte through per-byte tables
// that table-write items fill in; optional folding of a translated character.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                  Handshake
//  s_axis    in         tdata: byte_value, entry_target,          tvalid/tready
//                              entry_delete, entry_squeeze
//                       tuser: action, new_stream
//  m_axis    out        tdata: out_byte                          tvalid/tready
//  cfg       in         index 0 fold_enable, 1 fold_char         cfg_we_i
//
//  One item is accepted per cycle unless the input stalls; the table read data
//  and the item are registered into the decision stage, whose result is
//  registered into the output reg. The table memory read port and the last-byte
//  compare set that pace. Reset clears the per-slot valid bits at once, so each
//  slot reads as its own index with no marks; no clearing pass is needed and
//  items are taken right away. A stalled output holds the decision stage; input
//  stalls only when the decision stage is full and the output reg is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_translate_delete_squeeze #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input items
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [7:0] byte_value, [15:8] entry_target, [16] entry_delete,
  // [17] entry_squeeze, [23:18] zero
  input  wire logic [23:0]                     s_axis_tdata,
  // [0] action, [1] new_stream
  input  wire logic [1:0]                      s_axis_tuser,
  // Result items
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]                           m_axis_tdata,
  // Configuration writes
  input  wire logic                            cfg_we_i,
  input  wire logic [btds_pkg::CfgIdxW-1:0]    cfg_addr_i,
  input  wire logic [btds_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  // Only the first 256 slots can ever be addressed by a byte
  localparam int unsigned Depth = (TABLE_ENTRIES < 256) ? TABLE_ENTRIES : 256;
  localparam int unsigned SlotW = $clog2(Depth);

  typedef logic [SlotW-1:0] slot_lut_t [256];

  // Byte to slot map, worked out at elaboration
  function automatic slot_lut_t build_slot_lut();
    slot_lut_t lut;
    for (int i = 0; i < 256; i++) begin
      lut[i] = SlotW'(i % Depth);
    end
    return lut;
  endfunction

  localparam slot_lut_t SlotLut = build_slot_lut();

  logic             fold_enable_q;
  logic [7:0]       fold_char_q;

  logic             in_fire;
  logic             is_write;
  logic [SlotW-1:0] slot;
  btds_pkg::item_t  item;
  btds_pkg::entry_t wr_entry;
  btds_pkg::entry_t rd_entry;

  // Configuration registers; the user must write them only while the block is idle; the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_enable_q <= 1'b0;
      fold_char_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        btds_pkg::CfgFoldEnable: fold_enable_q <= cfg_wdata_i[0];
        btds_pkg::CfgFoldChar:   fold_char_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Unpack the input item
  assign in_fire             = s_axis_tvalid && s_axis_tready;
  assign item.action         = s_axis_tuser[0];
  assign item.new_stream     = s_axis_tuser[1];
  assign item.byte_value     = s_axis_tdata[7:0];
  assign wr_entry.target     = s_axis_tdata[15:8];
  assign wr_entry.del        = s_axis_tdata[16];
  assign wr_entry.squeeze    = s_axis_tdata[17];
  assign is_write            = (item.action == btds_pkg::ActTableWrite);
  assign slot                = SlotLut[item.byte_value];

  // Writes land at accept; the next item's read already sees them
  btds_table #(
    .Depth (Depth),
    .SlotW (SlotW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (in_fire && is_write),
    .rd_en_i    (in_fire && !is_write),
    .slot_i     (slot),
    .wr_entry_i (wr_entry),
    .rd_entry_o (rd_entry)
  );

  btds_filter u_filter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_fire_i     (in_fire),
    .item_i        (item),
    .entry_i       (rd_entry),
    .fold_enable_i (fold_enable_q),
    .fold_char_i   (fold_char_q),
    .ready_o       (s_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_byte_o    (m_axis_tdata),
    .out_ready_i   (m_axis_tready)
  );

endmodule

`default_nettype wire

### rtl/btds_table.sv
// ----------------------------------------------------------------------------
// btds_table: per-byte lookup memory
// One synchronous memory holds translate target, delete mark and squeeze mark
// for each slot. Per-slot valid bits, cleared by reset, make unwritten slots
// read as the identity/unmarked entry. Read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module btds_table #(
  parameter int unsigned Depth = 256,
  parameter int unsigned SlotW = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_en_i,
  input  wire logic               rd_en_i,
  input  wire logic [SlotW-1:0]   slot_i,
  input  wire btds_pkg::entry_t   wr_entry_i,
  output btds_pkg::entry_t        rd_entry_o
);

  btds_pkg::entry_t mem_q [Depth];
  logic [Depth-1:0] vld_q;

  btds_pkg::entry_t rd_data_q;
  logic             rd_vld_q;
  logic [SlotW-1:0] rd_slot_q;

  // Mark slots as written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[slot_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[slot_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[slot_i];
      rd_vld_q  <= vld_q[slot_i];
      rd_slot_q <= slot_i;
    end
  end

  // Unwritten slot: translate to its own index, no marks
  always_comb begin
    if (rd_vld_q) begin
      rd_entry_o = rd_data_q;
    end else begin
      rd_entry_o.squeeze = 1'b0;
      rd_entry_o.del     = 1'b0;
      rd_entry_o.target  = 8'(rd_slot_q);
    end
  end

endmodule

`default_nettype wire

### rtl/btds_filter.sv
// ----------------------------------------------------------------------------
// btds_filter: decision stage and output register
// Takes the looked-up entry, applies squeeze, delete and fold rules against
// the last output byte, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module btds_filter (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_fire_i,
  input  wire btds_pkg::item_t   item_i,
  input  wire btds_pkg::entry_t  entry_i,
  input  wire logic              fold_enable_i,
  input  wire logic [7:0]        fold_char_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  output logic [7:0]             out_byte_o,
  input  wire logic              out_ready_i
);

  logic            s1_vld_q;
  btds_pkg::item_t s1_item_q;
  logic            last_valid_q, last_valid_d;
  logic [7:0]      last_byte_q, last_byte_d;
  logic            out_vld_q;
  logic [7:0]      out_byte_q;

  logic       adv;
  logic       s1_fire;
  logic       lv;
  logic       emit;
  logic [7:0] res_byte;

  assign adv     = !out_vld_q || out_ready_i;
  assign s1_fire = s1_vld_q && adv;
  assign ready_o = !s1_vld_q || adv;

  always_comb begin
    lv           = s1_item_q.new_stream ? 1'b0 : last_valid_q;
    emit         = 1'b0;
    res_byte     = entry_i.target;
    last_valid_d = lv;
    last_byte_d  = last_byte_q;
    if (s1_item_q.action == btds_pkg::ActTableWrite) begin
      emit = 1'b0;
    end else if (entry_i.squeeze) begin
      res_byte     = s1_item_q.byte_value;
      emit         = !lv || (s1_item_q.byte_value != last_byte_q);
      last_byte_d  = s1_item_q.byte_value;
      last_valid_d = 1'b1;
    end else if (entry_i.del) begin
      emit = 1'b0;
    end else begin
      emit         = !(fold_enable_i && lv && (entry_i.target == last_byte_q) &&
                       (entry_i.target == fold_char_i));
      last_byte_d  = entry_i.target;
      last_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q     <= 1'b0;
      last_valid_q <= 1'b0;
      last_byte_q  <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      if (ready_o) begin
        s1_vld_q <= in_fire_i;
      end
      if (s1_fire) begin
        last_valid_q <= last_valid_d;
        last_byte_q  <= last_byte_d;
      end
      if (adv) begin
        out_vld_q <= s1_fire && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      s1_item_q <= item_i;
    end
    if (s1_fire && emit) begin
      out_byte_q <= res_byte;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_byte_o  = out_byte_q;

  // An emitted byte becomes the remembered last byte
  a_emit_tracks_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && emit) |=> (last_valid_q && (last_byte_q == out_byte_q)))
    else $error("last byte does not match emitted item");

  // A table write never produces an output item
  a_write_no_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (s1_item_q.action == btds_pkg::ActTableWrite)) |=> !out_vld_q)
    else $error("table write produced an output item");

  // A table write that starts a stream leaves no last byte
  a_write_new_stream : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_item_q.new_stream &&
     (s1_item_q.action == btds_pkg::ActTableWrite)) |=> !last_valid_q)
    else $error("stream start not cleared on table write");

endmodule

`default_nettype wire
